>>> sv/icp_pkg.sv
// shared types and constants for the ipv4 config text parser
// key table, character codes and the beat structs; no dependencies
package icp_pkg;

  localparam int unsigned NumKeys = 4;

  typedef logic [7:0] char_t;

  localparam char_t CharNul  = 8'h00;
  localparam char_t CharLf   = 8'h0a;
  localparam char_t CharCr   = 8'h0d;
  localparam char_t CharHash = 8'h23;
  localparam char_t CharDot  = 8'h2e;
  localparam char_t CharZero = 8'h30;
  localparam char_t CharNine = 8'h39;
  localparam char_t CharEq   = 8'h3d;

  localparam logic [3:0] AllKeys   = 4'hf;
  localparam logic [3:0] KeyPosSat = 4'd8;
  localparam logic [7:0] OctetMax  = 8'd255;

  typedef enum logic [1:0] {
    KeyAddress,
    KeyNetmask,
    KeyGateway,
    KeyDns
  } key_e;

  typedef struct packed {
    char_t text_byte;
    logic  is_last;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] host_address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
    logic [31:0] dns_server;
  } out_item_t;

  // result of matching one key character against all keys
  typedef struct packed {
    logic [3:0] cand;
    logic       hit;
    key_e       hit_key;
  } key_match_t;

  function automatic logic [3:0] key_len(key_e k);
    logic [3:0] len;
    unique case (k)
      KeyDns:  len = 4'd3;
      default: len = 4'd7;
    endcase
    return len;
  endfunction

  function automatic char_t key_text(key_e k, logic [2:0] pos);
    logic [63:0] s;
    unique case (k)
      KeyAddress: s = {"address", 8'h00};
      KeyNetmask: s = {"netmask", 8'h00};
      KeyGateway: s = {"gateway", 8'h00};
      default:    s = {"dns", 40'h0};
    endcase
    return s[8 * (3'd7 - pos) +: 8];
  endfunction

endpackage

>>> sv/ipv4_config_text_parser.sv
// ipv4 boot configuration text parser, top level
// uses icp_pkg and icp_key_match
//
// Takes one text byte per clock and, after the byte flagged is_last, delivers
// one verdict beat with status and the four parsed addresses (all zero when
// the status is invalid). A byte is registered at the input, then the line
// parser state and the result register are updated as the byte leaves the input
// register, so a verdict passes both registers before it reaches the output. The
// sustained rate is one byte per cycle; in_ready_o drops only while a last byte
// sits in the input register and the previous verdict has not yet been taken.
module ipv4_config_text_parser import icp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic [1:0] {
    PhStart,
    PhComment,
    PhKey,
    PhValue
  } line_phase_e;

  // input stage
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      in_fire, s1_fire;

  // output stage
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // parser state
  line_phase_e phase_q, phase_d;
  logic [3:0]  cand_q, cand_d;
  logic [3:0]  key_pos_q, key_pos_d;
  key_e        cur_key_q, cur_key_d;
  logic [3:0]  seen_q, seen_d;
  logic [1:0]  oct_idx_q, oct_idx_d;
  logic [7:0]  oct_val_q, oct_val_d;
  logic [1:0]  dig_cnt_q, dig_cnt_d;
  logic [31:0] addr_q [NumKeys];
  logic [31:0] addr_d [NumKeys];
  logic        pend_q, pend_d;
  logic        failed_q, failed_d;
  logic        ended_q, ended_d;

  char_t       c;
  logic [7:0]  digit;
  logic [11:0] acc;
  logic        active, close_req, shift_en, ok;
  logic [7:0]  shift_byte;
  key_e        shift_key;
  key_match_t  km;
  out_item_t   verdict;

  function automatic logic mask_ok(logic [31:0] m);
    logic [31:0] inv;
    inv = ~m;
    return (m != '0) && (m != '1) && ((inv & (inv + 32'd1)) == '0);
  endfunction

  assign in_ready_o = !(s1_valid_q && s1_item_q.is_last && out_valid_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && (!s1_item_q.is_last || !out_valid_q || out_ready_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  icp_key_match u_key_match (
    .char_i    (c),
    .key_pos_i (key_pos_q),
    .cand_i    (cand_q),
    .match_o   (km)
  );

  always_comb begin
    c     = s1_item_q.text_byte;
    digit = c - CharZero;
    acc   = {4'b0, oct_val_q} * 12'd10 + {4'b0, digit};

    phase_d   = phase_q;
    cand_d    = cand_q;
    key_pos_d = key_pos_q;
    cur_key_d = cur_key_q;
    seen_d    = seen_q;
    oct_idx_d = oct_idx_q;
    oct_val_d = oct_val_q;
    dig_cnt_d = dig_cnt_q;
    addr_d    = addr_q;
    pend_d    = pend_q;
    failed_d  = failed_q;
    ended_d   = ended_q;

    shift_en   = 1'b0;
    shift_byte = oct_val_q;
    shift_key  = cur_key_q;
    close_req  = 1'b0;
    ok         = 1'b0;
    verdict    = '0;
    active     = !failed_q && !ended_q;

    if (s1_fire) begin
      if (active) begin
        if (c == CharNul || c == CharLf) begin
          close_req = 1'b1;
          if (c == CharNul) ended_d = 1'b1;
        end else if (phase_q == PhComment) begin
          // comment text is skipped
        end else if (pend_q) begin
          failed_d = 1'b1;
        end else if (c == CharCr) begin
          if (phase_q == PhKey) failed_d = 1'b1;
          else                  pend_d   = 1'b1;
        end else if (phase_q == PhStart && c == CharHash) begin
          phase_d = PhComment;
        end else if (phase_q == PhStart || phase_q == PhKey) begin
          phase_d = PhKey;
          if (c == CharEq) begin
            if (!km.hit || seen_q[km.hit_key]) begin
              failed_d = 1'b1;
            end else begin
              cur_key_d = km.hit_key;
              phase_d   = PhValue;
              oct_idx_d = '0;
              oct_val_d = '0;
              dig_cnt_d = '0;
            end
          end else begin
            cand_d = km.cand;
            if (key_pos_q < KeyPosSat) key_pos_d = key_pos_q + 4'd1;
            if (km.cand == '0) failed_d = 1'b1;
          end
        end else begin
          if (c >= CharZero && c <= CharNine) begin
            if (dig_cnt_q == 2'd3 || acc > {4'b0, OctetMax}) begin
              failed_d = 1'b1;
            end else begin
              oct_val_d = acc[7:0];
              dig_cnt_d = dig_cnt_q + 2'd1;
            end
          end else if (c == CharDot) begin
            if (dig_cnt_q == '0 || oct_idx_q == 2'd3) begin
              failed_d = 1'b1;
            end else begin
              shift_en   = 1'b1;
              shift_byte = oct_val_q;
              shift_key  = cur_key_q;
              oct_idx_d  = oct_idx_q + 2'd1;
              oct_val_d  = '0;
              dig_cnt_d  = '0;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
      end

      // the last byte closes the open line unless the text already ended or failed
      if (s1_item_q.is_last && !failed_d && !ended_d) close_req = 1'b1;

      if (close_req) begin
        if (phase_d == PhKey) begin
          failed_d = 1'b1;
        end else if (phase_d == PhValue) begin
          if (oct_idx_d == 2'd3 && dig_cnt_d != '0) begin
            shift_en   = 1'b1;
            shift_byte = oct_val_d;
            shift_key  = cur_key_d;
            seen_d[cur_key_d] = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        phase_d   = PhStart;
        cand_d    = AllKeys;
        key_pos_d = '0;
        cur_key_d = KeyAddress;
        oct_idx_d = '0;
        oct_val_d = '0;
        dig_cnt_d = '0;
        pend_d    = 1'b0;
      end

      for (int j = 0; j < NumKeys; j++) begin
        if (shift_en && shift_key == key_e'(2'(j))) begin
          addr_d[j] = {addr_q[j][23:0], shift_byte};
        end
      end

      if (s1_item_q.is_last) begin
        ok = !failed_d && seen_d == AllKeys && mask_ok(addr_d[KeyNetmask]) &&
             addr_d[KeyAddress] != '0;
        verdict.status = !ok;
        if (ok) begin
          verdict.host_address    = addr_d[KeyAddress];
          verdict.subnet_mask     = addr_d[KeyNetmask];
          verdict.gateway_address = addr_d[KeyGateway];
          verdict.dns_server      = addr_d[KeyDns];
        end
        // start over for the next text
        phase_d   = PhStart;
        cand_d    = AllKeys;
        key_pos_d = '0;
        cur_key_d = KeyAddress;
        seen_d    = '0;
        oct_idx_d = '0;
        oct_val_d = '0;
        dig_cnt_d = '0;
        pend_d    = 1'b0;
        failed_d  = 1'b0;
        ended_d   = 1'b0;
        for (int j = 0; j < NumKeys; j++) addr_d[j] = '0;
      end
    end

    if (s1_fire && s1_item_q.is_last) out_valid_d = 1'b1;
    else if (out_ready_i)             out_valid_d = 1'b0;
    else                              out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhStart;
      cand_q      <= AllKeys;
      key_pos_q   <= '0;
      cur_key_q   <= KeyAddress;
      seen_q      <= '0;
      oct_idx_q   <= '0;
      oct_val_q   <= '0;
      dig_cnt_q   <= '0;
      pend_q      <= 1'b0;
      failed_q    <= 1'b0;
      ended_q     <= 1'b0;
      for (int j = 0; j < NumKeys; j++) addr_q[j] <= '0;
    end else begin
      if (in_fire)      s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      cand_q      <= cand_d;
      key_pos_q   <= key_pos_d;
      cur_key_q   <= cur_key_d;
      seen_q      <= seen_d;
      oct_idx_q   <= oct_idx_d;
      oct_val_q   <= oct_val_d;
      dig_cnt_q   <= dig_cnt_d;
      pend_q      <= pend_d;
      failed_q    <= failed_d;
      ended_q     <= ended_d;
      addr_q      <= addr_d;
    end
  end

  // beat payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) s1_item_q <= in_data_i;
    if (s1_fire && s1_item_q.is_last) out_item_q <= verdict;
  end

  // an accepted verdict always carries a nonzero address
  a_ok_has_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.status |-> out_item_q.host_address != '0)
    else $error("accepted verdict with zero address");

  // an invalid verdict carries no addresses
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.status |->
      out_item_q.host_address == '0 && out_item_q.subnet_mask == '0 &&
      out_item_q.gateway_address == '0 && out_item_q.dns_server == '0)
    else $error("invalid verdict with nonzero address");

  // input stalls only behind a waiting last byte
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_item_q.is_last && out_valid_q)
    else $error("input stalled without cause");

  // after a verdict the parser starts clean
  a_clean_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_item_q.is_last |=>
      seen_q == '0 && !failed_q && !ended_q && phase_q == PhStart)
    else $error("state not cleared after verdict");

  // failure is sticky until the last byte
  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(s1_fire && s1_item_q.is_last) |=> failed_q)
    else $error("failure flag dropped early");

endmodule

>>> sv/icp_key_match.sv
// key name matcher: narrows the candidate set on each key character
// and resolves the key when '=' arrives; uses icp_pkg
module icp_key_match import icp_pkg::*; (
  input  char_t      char_i,
  input  logic [3:0] key_pos_i,
  input  logic [3:0] cand_i,
  output key_match_t match_o
);

  always_comb begin
    match_o.cand    = cand_i;
    match_o.hit     = 1'b0;
    match_o.hit_key = KeyAddress;
    for (int k = 0; k < NumKeys; k++) begin
      // on '=' the highest still-possible key of exactly this length wins
      if (cand_i[k] && key_len(key_e'(2'(k))) == key_pos_i) begin
        match_o.hit     = 1'b1;
        match_o.hit_key = key_e'(2'(k));
      end
      if (key_pos_i >= key_len(key_e'(2'(k))) ||
          key_text(key_e'(2'(k)), key_pos_i[2:0]) != char_i) begin
        match_o.cand[k] = 1'b0;
      end
    end
  end

endmodule

>>> tb/tb_ipv4_config_text_parser.sv
// self-checking testbench for ipv4_config_text_parser
// depends on icp_pkg and the parser rtl; holds its own line parser to predict verdicts
`timescale 1ns / 100ps

module tb_ipv4_config_text_parser import icp_pkg::*; ();

  localparam int StuckLimit   = 5000;
  localparam int RxHoldCycles = 400;
  localparam int SettleCycles = 8;

  typedef enum logic [2:0] {
    LnStart,
    LnComment,
    LnKey,
    LnValue
  } line_phase_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // predictor state
  line_phase_e ln_phase;
  logic [3:0]  key_cand;
  logic [3:0]  key_pos;
  key_e        key_sel;
  logic [3:0]  keys_seen;
  logic [1:0]  oct_idx;
  logic [7:0]  oct_acc;
  logic [1:0]  dig_cnt;
  logic [31:0] addr_acc [NumKeys];
  logic        cr_held;
  logic        bad;
  logic        text_done;

  out_item_t verdict_q [$];
  char_t     txt_q [$];

  int fail_count = 0;
  int stuck_cycles = 0;
  int beat_count = 0;
  int tx_idle_pct = 25;
  int rx_idle_pct = 25;
  bit rx_hold_req = 1'b0;

  ipv4_config_text_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic string key_name(key_e k);
    case (k)
      KeyAddress: return "address";
      KeyNetmask: return "netmask";
      KeyGateway: return "gateway";
      default:    return "dns";
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(16, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic start_line();
    ln_phase = LnStart;
    key_cand = AllKeys;
    key_pos  = '0;
    key_sel  = KeyAddress;
    oct_idx  = '0;
    oct_acc  = '0;
    dig_cnt  = '0;
    cr_held  = 1'b0;
  endtask

  task automatic restart_text();
    start_line();
    keys_seen = '0;
    foreach (addr_acc[i]) addr_acc[i] = '0;
    bad       = 1'b0;
    text_done = 1'b0;
  endtask

  task automatic close_cfg_line();
    if (ln_phase == LnKey) begin
      bad = 1'b1;
    end else if (ln_phase == LnValue) begin
      if (oct_idx == 2'd3 && dig_cnt != 2'd0) begin
        addr_acc[key_sel] = {addr_acc[key_sel][23:0], oct_acc};
        keys_seen[key_sel] = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end
    start_line();
  endtask

  // advance the predicted parser by one accepted beat, queue a verdict on the last one
  task automatic parse_beat(in_item_t b);
    char_t       c;
    int          hit;
    int          v;
    string       nm;
    logic [31:0] inv;
    logic        ok;
    out_item_t   res;
    c = b.text_byte;
    if (!bad && !text_done) begin
      if (c == CharNul || c == CharLf) begin
        close_cfg_line();
        if (c == CharNul) text_done = 1'b1;
      end else if (ln_phase == LnComment) begin
        // comment text is skipped
      end else if (cr_held) begin
        bad = 1'b1;
      end else if (c == CharCr) begin
        if (ln_phase == LnKey) bad = 1'b1;
        else cr_held = 1'b1;
      end else if (ln_phase == LnStart && c == CharHash) begin
        ln_phase = LnComment;
      end else begin
        if (ln_phase == LnStart) ln_phase = LnKey;
        if (ln_phase == LnKey) begin
          if (c == CharEq) begin
            hit = NumKeys;
            for (int k = 0; k < NumKeys; k++) begin
              nm = key_name(key_e'(k));
              if (key_cand[k] && nm.len() == key_pos) hit = k;
            end
            if (hit == NumKeys || keys_seen[hit]) begin
              bad = 1'b1;
            end else begin
              key_sel  = key_e'(hit);
              ln_phase = LnValue;
              oct_idx  = '0;
              oct_acc  = '0;
              dig_cnt  = '0;
            end
          end else begin
            for (int k = 0; k < NumKeys; k++) begin
              nm = key_name(key_e'(k));
              if (key_pos >= nm.len() || nm[key_pos] != c) key_cand[k] = 1'b0;
            end
            if (key_pos < KeyPosSat) key_pos++;
            if (key_cand == '0) bad = 1'b1;
          end
        end else if (c >= CharZero && c <= CharNine) begin
          v = int'(oct_acc) * 10 + int'(c - CharZero);
          if (dig_cnt >= 2'd3 || v > 255) begin
            bad = 1'b1;
          end else begin
            oct_acc = 8'(v);
            dig_cnt++;
          end
        end else if (c == CharDot) begin
          if (dig_cnt == 2'd0 || oct_idx >= 2'd3) begin
            bad = 1'b1;
          end else begin
            addr_acc[key_sel] = {addr_acc[key_sel][23:0], oct_acc};
            oct_idx++;
            oct_acc = '0;
            dig_cnt = '0;
          end
        end else begin
          bad = 1'b1;
        end
      end
    end
    if (b.is_last) begin
      if (!bad && !text_done) close_cfg_line();
      inv = ~addr_acc[KeyNetmask];
      ok = !bad && keys_seen == AllKeys && addr_acc[KeyNetmask] != 32'h0 &&
           addr_acc[KeyNetmask] != 32'hffff_ffff && (inv & (inv + 32'd1)) == 32'h0 &&
           addr_acc[KeyAddress] != 32'h0;
      res.status          = !ok;
      res.host_address    = ok ? addr_acc[KeyAddress] : 32'h0;
      res.subnet_mask     = ok ? addr_acc[KeyNetmask] : 32'h0;
      res.gateway_address = ok ? addr_acc[KeyGateway] : 32'h0;
      res.dns_server      = ok ? addr_acc[KeyDns] : 32'h0;
      verdict_q.push_back(res);
      restart_text();
    end
  endtask

  task automatic send_beat(char_t c, logic last);
    in_item_t b;
    int       gap;
    b.text_byte = c;
    b.is_last   = last;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    beat_count++;
    parse_beat(b);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = rand_gap();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) txt_q.push_back(s[i]);
  endtask

  // one key=a.b.c.d line, octets sometimes zero padded
  task automatic add_entry(key_e k, logic [31:0] val, bit cr, bit nl);
    string num;
    add_str(key_name(k));
    txt_q.push_back(CharEq);
    for (int i = 3; i >= 0; i--) begin
      num = $sformatf("%0d", val[8*i +: 8]);
      if ($urandom_range(0, 4) == 0) repeat (3 - num.len()) txt_q.push_back(CharZero);
      add_str(num);
      if (i > 0) txt_q.push_back(CharDot);
    end
    if (cr) txt_q.push_back(CharCr);
    if (nl) txt_q.push_back(CharLf);
  endtask

  task automatic build_config(string a, string m, string g, string d);
    add_str("address=");
    add_str(a);
    add_str("\nnetmask=");
    add_str(m);
    add_str("\ngateway=");
    add_str(g);
    add_str("\ndns=");
    add_str(d);
  endtask

  // sends the buffered text, flagging its final beat
  task automatic send_text();
    for (int i = 0; i < txt_q.size(); i++) send_beat(txt_q[i], i == txt_q.size() - 1);
    txt_q.delete();
  endtask

  task automatic send_str(string s);
    add_str(s);
    send_text();
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (verdict_q.size() > 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic test_valid_configs();
    // netmask with one bit set, padded octets, cr line ends, comment and empty lines
    add_str("# boot config\015\n\naddress=255.255.255.255\015\nnetmask=128.0.0.0\n");
    add_str("\015\ngateway=0.0.0.0\ndns=010.001.000.099");
    send_text();
    add_str("dns=8.8.4.4\ngateway=192.168.1.1\nnetmask=255.255.255.254\naddress=0.0.0.1\n");
    send_text();
    // last byte a stripped cr
    build_config("10.0.0.2", "255.255.0.0", "10.0.0.1", "10.0.0.1\015");
    send_text();
    build_config("1.2.3.4", "255.255.255.255", "1.1.1.1", "1.1.1.1");
    send_text();
    build_config("1.2.3.4", "0.0.0.0", "1.1.1.1", "1.1.1.1");
    send_text();
    build_config("1.2.3.4", "255.0.255.0", "1.1.1.1", "1.1.1.1");
    send_text();
    build_config("000.0.00.0", "255.255.255.0", "1.1.1.1", "1.1.1.1");
    send_text();
    send_str("address=1.2.3.4\nnetmask=255.0.0.0\ngateway=1.1.1.1\n");
    wait_results();
  endtask

  task automatic test_malformed_lines();
    send_str("=1.2.3.4");
    send_str("adress=1.2.3.4");
    send_str("address");
    send_str("address1.2.3.4");
    send_str("addresses=1.2.3.4");
    send_str("dnsx=1.2.3.4");
    send_str("dns==1.2.3.4");
    send_str("dns=1.2.3.4=5");
    send_str("dns=1.2.3");
    send_str("dns=1.2.3.4.5");
    send_str("dns=1..3.4");
    send_str("dns=.1.2.3");
    send_str("dns=1.2.3.");
    send_str("dns=0001.2.3.4");
    send_str("dns=1.256.3.4");
    send_str("dns=1.2.3.4x");
    send_str("dns=1.2\015.3.4");
    send_str("dn\015s=1.2.3.4");
    send_str("dns=1.2.3.4\015\015\n");
    send_str("\015#x\n");
    send_str("#\015\377=\n");
    build_config("1.2.3.4", "255.0.0.0", "1.1.1.1", "1.1.1.1\ndns=2.2.2.2");
    send_text();
    wait_results();
  endtask

  task automatic test_text_end();
    // zero byte ends the text, trailing garbage ignored
    build_config("192.168.0.10", "255.255.255.0", "192.168.0.1", "9.9.9.9\n");
    txt_q.push_back(CharNul);
    add_str("zz=\377");
    send_text();
    build_config("172.16.0.5", "255.240.0.0", "172.16.0.1", "4.4.4.4");
    txt_q.push_back(CharNul);
    send_text();
    // failure stays set even if good lines follow
    add_str("dns=1.2.3.4x\n");
    build_config("1.2.3.4", "255.0.0.0", "1.1.1.1", "1.1.1.1");
    send_text();
    send_beat(8'hff, 1'b1);
    send_beat(CharNul, 1'b1);
    send_beat(CharLf, 1'b1);
    send_beat(CharHash, 1'b1);
    wait_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    repeat (6) begin
      repeat ($urandom_range(0, 1)) txt_q.push_back(char_t'($urandom_range(0, 255)));
      txt_q.push_back(CharHash);
      send_text();
    end
    wait_results();
    // full configs back to back at full rate
    repeat (2) begin
      build_config("10.1.2.3", "255.255.255.128", "10.1.2.1", "10.1.2.1\n");
      send_text();
    end
    wait_results();
  endtask

  // mostly well formed configs with random content, some broken, some noise
  task automatic gen_text();
    key_e        order [NumKeys];
    key_e        tmp;
    int          j;
    int          pick;
    int          plen;
    int          n;
    logic [31:0] val;
    char_t       trash;
    string       specials;
    string       digits;
    specials = "=.\015#9\n0";
    digits   = "0123456789.";
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 8)) txt_q.push_back(char_t'($urandom_range(0, 255)));
    end else begin
      order = '{KeyAddress, KeyNetmask, KeyGateway, KeyDns};
      for (int i = NumKeys - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < NumKeys; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 2))
            0:       add_str("# boot\n");
            1:       add_str("\n");
            default: add_str("\015\n");
          endcase
        end
        if (order[i] == KeyNetmask) begin
          if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 1) ? 32 : 0;
          else plen = $urandom_range(1, 31);
          val = (plen == 0) ? 32'h0 : ~32'h0 << (32 - plen);
        end else if (order[i] == KeyAddress && $urandom_range(0, 19) == 0) begin
          val = 32'h0;
        end else begin
          val = $urandom();
        end
        add_entry(order[i], val, $urandom_range(0, 3) == 0, i < 3 || $urandom_range(0, 1));
      end
      if (pick >= 70) begin
        case ($urandom_range(0, 3))
          0: txt_q[$urandom_range(0, txt_q.size() - 1)] = char_t'($urandom_range(0, 255));
          1: txt_q[$urandom_range(0, txt_q.size() - 1)] =
               specials[$urandom_range(0, specials.len() - 1)];
          2: begin
            n = $urandom_range(1, txt_q.size());
            while (txt_q.size() > n) trash = txt_q.pop_back();
          end
          default: begin
            // stray line with random digits and dots, always a repeated key
            txt_q.push_back(CharLf);
            add_str(key_name(key_e'($urandom_range(0, 3))));
            txt_q.push_back(CharEq);
            repeat ($urandom_range(1, 14))
              txt_q.push_back(digits[$urandom_range(0, digits.len() - 1)]);
          end
        endcase
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      txt_q.push_back(CharNul);
      repeat ($urandom_range(0, 4)) txt_q.push_back(char_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_texts();
    int texts;
    int first_beat;
    texts      = 0;
    first_beat = beat_count;
    while (texts < 3 || beat_count - first_beat < 200) begin
      if (texts % 2 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 15;
          default: tx_idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 15;
          default: rx_idle_pct = 40;
        endcase
      end
      gen_text();
      send_text();
      texts++;
    end
    wait_results();
  endtask

  // receiver: random stalls, plus one long hold when asked
  initial begin : rx_proc
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall == 0 && rx_hold_req) begin
        stall       = RxHoldCycles;
        rx_hold_req = 1'b0;
      end else if (stall == 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        stall = rand_gap();
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict beat with none expected, expected none, actual %h",
                 $time, out_data_o);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("host_address", want.host_address, out_data_o.host_address);
        check_field("subnet_mask", want.subnet_mask, out_data_o.subnet_mask);
        check_field("gateway_address", want.gateway_address, out_data_o.gateway_address);
        check_field("dns_server", want.dns_server, out_data_o.dns_server);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StuckLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    restart_text();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_valid_configs();
    test_malformed_lines();
    test_text_end();
    test_backpressure();
    test_random_texts();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
